// ----- rtl/log_record_replay_checker_unit_assert.svh -----
// Assertion macros shared by the RTL files.
`ifndef LOG_RECORD_REPLAY_CHECKER_UNIT_ASSERT_SVH
`define LOG_RECORD_REPLAY_CHECKER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define LRRC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LRRC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LRRC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define LRRC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/lrrc_pkg.sv -----
`timescale 1ns / 1ps

package lrrc_pkg;

    localparam int PAGE_BYTES_DEFAULT = 4096;
    localparam int OFF_W              = 12;
    localparam int CFG_INDEX_W        = 8;

    localparam logic [0:0] ACT_DATA = 1'b0;
    localparam logic [0:0] ACT_END  = 1'b1;

    localparam logic [0:0] KIND_PAYLOAD = 1'b0;
    localparam logic [0:0] KIND_VERDICT = 1'b1;

    localparam logic [3:0] ST_APPLY     = 4'd0;
    localparam logic [3:0] ST_MARKER    = 4'd1;
    localparam logic [3:0] ST_FILTERED  = 4'd2;
    localparam logic [3:0] ST_CHECKPT   = 4'd3;
    localparam logic [3:0] ST_BAD_LEN   = 4'd4;
    localparam logic [3:0] ST_CRC_BAD   = 4'd5;
    localparam logic [3:0] ST_PAST_TIME = 4'd6;
    localparam logic [3:0] ST_TRUNC     = 4'd7;
    localparam logic [3:0] ST_CLEAN_END = 4'd8;

    localparam logic [1:0] MODE_PAGE0 = 2'd0;
    localparam logic [1:0] MODE_SKIP0 = 2'd1;
    localparam logic [1:0] MODE_ALL   = 2'd2;
    localparam logic [1:0] MODE_TIME  = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODE       = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHECKPOINT = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET     = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENCRYPT    = 8'd3;

    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;
    localparam logic [31:0] MARKER_FIRST = 32'hFFFFFFFC;

    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        checkpoint_seq;
        logic signed [63:0] target_time;
        logic               encrypt_enabled;
    } cfg_t;

    typedef struct packed {
        logic [0:0]       kind;
        logic [3:0]       status;
        logic [31:0]      seq_number;
        logic [31:0]      page_number;
        logic [15:0]      record_length;
        logic [63:0]      record_time;
        logic [7:0]       payload_byte;
        logic [OFF_W-1:0] page_offset;
        logic             needs_encrypt;
    } result_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/lrrc_parser.sv -----
`timescale 1ns / 1ps
`include "log_record_replay_checker_unit_assert.svh"

module lrrc_parser #(
    parameter int PAGE_BYTES = lrrc_pkg::PAGE_BYTES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic [0:0]        action,
    input  logic [7:0]        data_byte,
    input  lrrc_pkg::cfg_t    cfg,
    output logic              res_valid,
    output lrrc_pkg::result_t res
);
    import lrrc_pkg::*;

    localparam int CNT_W = $clog2(PAGE_BYTES + 1);

    localparam logic [1:0] PH_HEAD = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_CRC  = 2'd2;

    localparam logic [CNT_W-1:0] CNT_SEQ_END  = CNT_W'(4);
    localparam logic [CNT_W-1:0] CNT_PAGE_END = CNT_W'(8);
    localparam logic [CNT_W-1:0] CNT_LEN_END  = CNT_W'(10);
    localparam logic [CNT_W-1:0] CNT_HEAD_END = CNT_W'(18);
    localparam logic [CNT_W-1:0] CNT_CRC_END  = CNT_W'(4);
    localparam logic [16:0]      PAGE_LIMIT   = 17'(PAGE_BYTES);

    logic [1:0]       phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      seq_reg, seq_next;
    logic [31:0]      page_reg, page_next;
    logic [15:0]      length_reg, length_next;
    logic [63:0]      time_reg, time_next;
    logic [31:0]      crc_reg, crc_next;
    logic [31:0]      stored_reg, stored_next;
    logic             filt_reg, filt_next;
    logic             stop_reg, stop_next;

    logic [31:0]          cap_seq, cap_page;
    logic [15:0]          cap_len;
    logic [63:0]          cap_time;
    logic [CNT_W-1:0]     cnt_inc;
    logic [31:0]          crc_upd, stored_upd;
    logic [2:0]           tidx;
    logic                 len_bad, time_late, crc_ok, rearm;
    logic [OFF_W+CNT_W-1:0] off_ext;

    always_comb
    begin
        cap_seq    = seq_reg;
        cap_page   = page_reg;
        cap_len    = length_reg;
        cap_time   = time_reg;
        cnt_inc    = cnt_reg + CNT_W'(1);
        crc_upd    = crc32_byte(crc_reg, data_byte);
        stored_upd = stored_reg | ({24'd0, data_byte} << {cnt_reg[1:0], 3'b000});
        tidx       = cnt_reg[2:0] - 3'd2;
        off_ext    = {{OFF_W{1'b0}}, cnt_reg};

        // capture header byte
        if (in_fire && !stop_reg && phase_reg == PH_HEAD && action == ACT_DATA) begin
            if (cnt_reg < CNT_SEQ_END) begin
                cap_seq[{cnt_reg[1:0], 3'b000} +: 8] =
                    seq_reg[{cnt_reg[1:0], 3'b000} +: 8] | data_byte;
            end else if (cnt_reg < CNT_PAGE_END) begin
                cap_page[{cnt_reg[1:0], 3'b000} +: 8] =
                    page_reg[{cnt_reg[1:0], 3'b000} +: 8] | data_byte;
            end else if (cnt_reg < CNT_LEN_END) begin
                cap_len[{cnt_reg[0], 3'b000} +: 8] =
                    length_reg[{cnt_reg[0], 3'b000} +: 8] | data_byte;
            end else if (cnt_reg < CNT_HEAD_END) begin
                cap_time[{tidx, 3'b000} +: 8] = time_reg[{tidx, 3'b000} +: 8] | data_byte;
            end
        end

        len_bad   = (cap_len == 16'd0) || ({1'b0, cap_len} > PAGE_LIMIT);
        time_late = $signed(cap_time) > cfg.target_time;
        crc_ok    = (crc_reg ^ CRC_INIT) == stored_upd;

        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        seq_next    = cap_seq;
        page_next   = cap_page;
        length_next = cap_len;
        time_next   = cap_time;
        crc_next    = crc_reg;
        stored_next = stored_reg;
        filt_next   = filt_reg;
        stop_next   = stop_reg;
        rearm       = 1'b0;

        res_valid         = 1'b0;
        res.kind          = KIND_VERDICT;
        res.status        = ST_APPLY;
        res.seq_number    = cap_seq;
        res.page_number   = cap_page;
        res.record_length = cap_len;
        res.record_time   = cap_time;
        res.payload_byte  = 8'd0;
        res.page_offset   = '0;
        res.needs_encrypt = 1'b0;

        if (in_fire) begin
            if (action == ACT_END) begin
                if (!stop_reg) begin
                    res_valid = 1'b1;
                    if (phase_reg == PH_HEAD && cnt_reg == '0) begin
                        res.status = ST_CLEAN_END;
                    end else if (filt_reg) begin
                        res.status = ST_FILTERED;
                    end else begin
                        res.status = ST_TRUNC;
                    end
                end
                rearm = 1'b1;
            end else if (!stop_reg) begin
                unique case (phase_reg)
                    PH_HEAD:
                    begin
                        crc_next = crc_upd;
                        cnt_next = cnt_inc;
                        if (cnt_inc == CNT_LEN_END && cfg.mode != MODE_TIME) begin
                            if (len_bad) begin
                                res_valid  = 1'b1;
                                res.status = ST_BAD_LEN;
                                stop_next  = 1'b1;
                            end else if ((cfg.mode == MODE_PAGE0 && cap_page != 32'd0) ||
                                         (cfg.mode == MODE_SKIP0 && cap_page == 32'd0)) begin
                                filt_next = 1'b1;
                            end
                        end else if (cnt_inc == CNT_HEAD_END) begin
                            if (len_bad) begin
                                res_valid  = 1'b1;
                                res.status = ST_BAD_LEN;
                                stop_next  = 1'b1;
                            end else if (cfg.mode == MODE_TIME && !filt_reg && time_late) begin
                                res_valid  = 1'b1;
                                res.status = ST_PAST_TIME;
                                stop_next  = 1'b1;
                            end else begin
                                phase_next = PH_BODY;
                                cnt_next   = '0;
                            end
                        end
                    end
                    PH_BODY:
                    begin
                        crc_next = crc_upd;
                        if (!filt_reg) begin
                            res_valid        = 1'b1;
                            res.kind         = KIND_PAYLOAD;
                            res.payload_byte = data_byte;
                            res.page_offset  = off_ext[OFF_W-1:0];
                        end
                        cnt_next = cnt_inc;
                        if (17'(cnt_inc) >= 17'(length_reg)) begin
                            phase_next = PH_CRC;
                            cnt_next   = '0;
                        end
                    end
                    PH_CRC:
                    begin
                        stored_next = stored_upd;
                        cnt_next    = cnt_inc;
                        if (cnt_inc >= CNT_CRC_END) begin
                            res_valid = 1'b1;
                            if (filt_reg) begin
                                res.status = ST_FILTERED;
                                rearm      = 1'b1;
                            end else if (!crc_ok) begin
                                res.status = ST_CRC_BAD;
                                stop_next  = 1'b1;
                            end else begin
                                if (cfg.mode == MODE_TIME) begin
                                    res.status = ST_APPLY;
                                end else if (seq_reg <= cfg.checkpoint_seq) begin
                                    res.status = ST_CHECKPT;
                                end else if (page_reg >= MARKER_FIRST) begin
                                    res.status = ST_MARKER;
                                end else begin
                                    res.status = ST_APPLY;
                                end
                                res.needs_encrypt = (res.status == ST_APPLY) &&
                                                    cfg.encrypt_enabled && (page_reg != 32'd0);
                                rearm = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        if (rearm) begin
            phase_next  = PH_HEAD;
            cnt_next    = '0;
            seq_next    = 32'd0;
            page_next   = 32'd0;
            length_next = 16'd0;
            time_next   = 64'd0;
            crc_next    = CRC_INIT;
            stored_next = 32'd0;
            filt_next   = 1'b0;
            stop_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_HEAD;
            cnt_reg    <= '0;
            seq_reg    <= 32'd0;
            page_reg   <= 32'd0;
            length_reg <= 16'd0;
            time_reg   <= 64'd0;
            crc_reg    <= CRC_INIT;
            stored_reg <= 32'd0;
            filt_reg   <= 1'b0;
            stop_reg   <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            seq_reg    <= seq_next;
            page_reg   <= page_next;
            length_reg <= length_next;
            time_reg   <= time_next;
            crc_reg    <= crc_next;
            stored_reg <= stored_next;
            filt_reg   <= filt_next;
            stop_reg   <= stop_next;
        end
    end

    `LRRC_ASSERT_IMP(a_body_below_len, clk, rst_n, phase_reg == PH_BODY, 17'(cnt_reg) < 17'(length_reg), "body count reached record length")
    `LRRC_ASSERT_IMP(a_stopped_silent, clk, rst_n, in_fire && stop_reg && action == ACT_DATA, !res_valid, "result while stopped")
    `LRRC_ASSERT_IMP(a_payload_in_body, clk, rst_n, res_valid && res.kind == KIND_PAYLOAD, phase_reg == PH_BODY && !filt_reg, "payload outside unfiltered body")

endmodule

// ----- rtl/lrrc_result_buf.sv -----
`timescale 1ns / 1ps
`include "log_record_replay_checker_unit_assert.svh"

module lrrc_result_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lrrc_pkg::result_t push_data,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_ready,
    output lrrc_pkg::result_t head
);
    import lrrc_pkg::*;

    logic [1:0] cnt_reg, cnt_next;
    result_t    head_reg, tail_reg;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign ready     = (cnt_reg != 2'd2);
    assign pop       = out_valid && out_ready;
    assign head      = head_reg;
    assign cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            // advance the skid entry, or take the new request directly
            if (cnt_reg == 2'd2) begin
                head_reg <= tail_reg;
            end else if (push) begin
                head_reg <= push_data;
            end
        end else if (push) begin
            if (cnt_reg == 2'd0) begin
                head_reg <= push_data;
            end else begin
                tail_reg <= push_data;
            end
        end
    end

    `LRRC_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg != 2'd3, "buffer count out of range")
    `LRRC_ASSERT_IMP(a_no_push_full, clk, rst_n, cnt_reg == 2'd2, !push, "push into full buffer")
    `LRRC_ASSERT_NXT(a_head_hold, clk, rst_n, out_valid && !out_ready, $stable(head_reg) && cnt_reg != 2'd0, "waiting head changed")

endmodule

// ----- rtl/log_record_replay_checker_unit.sv -----
`timescale 1ns / 1ps

// Write-ahead log record checker. Feed the log stream one byte per request
// (action 0) and mark the end of the stream with action 1. Each record is
// parsed as sequence number, page number, length, timestamp, payload and a
// reflected CRC-32; payload bytes come out as they arrive with their page
// offset, and each record closes with one verdict. Payload results stay
// provisional until that verdict. A request is taken every cycle while the
// two-entry result buffer has room: the byte-wise CRC update and field capture
// are combinational between the parser state and the result buffer, so one
// byte per cycle is sustained as long as results are taken. Configuration
// writes are always ready and should be issued only while the block is idle.
module log_record_replay_checker_unit #(
    parameter int PAGE_BYTES = lrrc_pkg::PAGE_BYTES_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [0:0]                       action,
    input  logic [7:0]                       data_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [0:0]                       kind,
    output logic [3:0]                       status,
    output logic [31:0]                      seq_number,
    output logic [31:0]                      page_number,
    output logic [15:0]                      record_length,
    output logic signed [63:0]               record_time,
    output logic [7:0]                       payload_byte,
    output logic [lrrc_pkg::OFF_W-1:0]       page_offset,
    output logic                             needs_encrypt,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lrrc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]                      cfg_data
);
    import lrrc_pkg::*;

    cfg_t    cfg_reg;
    result_t res, head;
    logic    res_valid, in_fire;

    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.mode            <= MODE_ALL;
            cfg_reg.checkpoint_seq  <= 32'd0;
            cfg_reg.target_time     <= 64'sd0;
            cfg_reg.encrypt_enabled <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MODE:       cfg_reg.mode            <= cfg_data[1:0];
                CFG_CHECKPOINT: cfg_reg.checkpoint_seq  <= cfg_data[31:0];
                CFG_TARGET:     cfg_reg.target_time     <= cfg_data;
                CFG_ENCRYPT:    cfg_reg.encrypt_enabled <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    lrrc_parser #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .action    (action),
        .data_byte (data_byte),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    lrrc_result_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .ready     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign kind          = head.kind;
    assign status        = head.status;
    assign seq_number    = head.seq_number;
    assign page_number   = head.page_number;
    assign record_length = head.record_length;
    assign record_time   = head.record_time;
    assign payload_byte  = head.payload_byte;
    assign page_offset   = head.page_offset;
    assign needs_encrypt = head.needs_encrypt;

endmodule
